// ----- hw/rtl/lpsmd_pkg.sv -----
// Shared types and constants for the line-follower PD steering and motor drive block.
// No dependencies; used by every module in hw/rtl.
package lpsmd_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int POS_STEP     = 1000;
    localparam int POS_MAX      = (SENSOR_COUNT - 1) * POS_STEP;

    localparam int POS_W    = 13;
    localparam int SPEED_W  = 8;
    localparam int GAIN_W   = 16;
    localparam int ERR_W    = 14;
    localparam int CORR_W   = 21;
    localparam int STEER_W  = 16;
    localparam int FRAC_W   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KD     = 2'd3;

    localparam logic [POS_W-1:0]   CENTRE_RST = 13'd3500;
    localparam logic [SPEED_W-1:0] BASE_RST   = 8'd155;
    localparam logic [GAIN_W-1:0]  GAIN_RST   = 16'd410;

    typedef struct packed {
        logic                 forward;
        logic [SPEED_W-1:0]   duty;
    } t_wheel;

    typedef struct packed {
        logic [POS_W-1:0]     centre;
        logic [SPEED_W-1:0]   base;
        logic [GAIN_W-1:0]    kp;
        logic [GAIN_W-1:0]    kd;
    } t_cfg;

endpackage

// ----- hw/rtl/line_pd_steering_motor_drive.sv -----
// Line-follower PD steering with differential motor drive, top level.
// One stage: PD products, clipping and duty sit between the input reg and result reg.
// Throughput: one word per cycle while the output is not stalled.
// Reset (i_rst_n low, synchronous): both stages empty, previous error 0,
// registers back to centre 3500, base 155, gains 410. Config port always ready.
module line_pd_steering_motor_drive (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lpsmd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [12:0] line_position
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] left_forward, [8:1] left_duty, [9] right_forward, [17:10] right_duty,
    // [33:18] steer_value, [39:34] zero
    output logic [lpsmd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lpsmd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lpsmd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int PW = lpsmd_pkg::POS_W;
    localparam int EW = lpsmd_pkg::ERR_W;
    localparam int TW = lpsmd_pkg::STEER_W;

    lpsmd_pkg::t_cfg                      r_cfg;
    logic [PW-1:0]                        r_pos;
    logic                                 r_in_vld;
    logic signed [EW-1:0]                 r_prev_err;
    logic                                 r_out_vld;
    lpsmd_pkg::t_wheel                    r_left;
    lpsmd_pkg::t_wheel                    r_right;
    logic signed [TW-1:0]                 r_steer;

    logic signed [EW-1:0]                 err;
    logic signed [lpsmd_pkg::CORR_W-1:0]  corr;
    logic signed [TW-1:0]                 steer;
    lpsmd_pkg::t_wheel                    left_w;
    lpsmd_pkg::t_wheel                    right_w;
    logic                                 advance;
    logic                                 in_acc;

    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(lpsmd_pkg::OUT_TDATA_W - 2*9 - TW){1'b0}}, r_steer,
                            r_right.duty, r_right.forward, r_left.duty, r_left.forward};

    lpsmd_pd_core u_pd (
        .i_pos      (r_pos),
        .i_cfg      (r_cfg),
        .i_prev_err (r_prev_err),
        .o_err      (err),
        .o_corr     (corr),
        .o_steer    (steer)
    );

    lpsmd_motor_drive u_left (
        .i_base  (r_cfg.base),
        .i_corr  (corr),
        .i_sub   (1'b0),
        .o_wheel (left_w)
    );

    lpsmd_motor_drive u_right (
        .i_base  (r_cfg.base),
        .i_corr  (corr),
        .i_sub   (1'b1),
        .o_wheel (right_w)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.centre <= lpsmd_pkg::CENTRE_RST;
            r_cfg.base   <= lpsmd_pkg::BASE_RST;
            r_cfg.kp     <= lpsmd_pkg::GAIN_RST;
            r_cfg.kd     <= lpsmd_pkg::GAIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lpsmd_pkg::CFG_CENTRE: r_cfg.centre <= i_cfg_data[PW-1:0];
                lpsmd_pkg::CFG_BASE:   r_cfg.base   <= i_cfg_data[lpsmd_pkg::SPEED_W-1:0];
                lpsmd_pkg::CFG_KP:     r_cfg.kp     <= i_cfg_data;
                lpsmd_pkg::CFG_KD:     r_cfg.kd     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_prev_err <= '0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld  <= 1'b1;
                r_prev_err <= err;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pos <= s_axis_tdata[PW-1:0];
        end
        if (advance) begin
            r_left  <= left_w;
            r_right <= right_w;
            r_steer <= steer;
        end
    end

endmodule

// ----- hw/rtl/lpsmd_pd_core.sv -----
// PD core: clamps the position, forms the error, the PD sum, the truncated correction
// and the saturated steer value. Depends on lpsmd_pkg.
module lpsmd_pd_core (
    input  logic [lpsmd_pkg::POS_W-1:0]          i_pos,
    input  lpsmd_pkg::t_cfg                      i_cfg,
    input  logic signed [lpsmd_pkg::ERR_W-1:0]   i_prev_err,
    output logic signed [lpsmd_pkg::ERR_W-1:0]   o_err,
    output logic signed [lpsmd_pkg::CORR_W-1:0]  o_corr,
    output logic signed [lpsmd_pkg::STEER_W-1:0] o_steer
);
    localparam int PW = lpsmd_pkg::POS_W;
    localparam int EW = lpsmd_pkg::ERR_W;
    localparam int GW = lpsmd_pkg::GAIN_W;
    localparam int PRW = GW + 1 + EW;        // kp * err
    localparam int DRW = GW + 1 + EW + 1;    // kd * diff
    localparam int SW  = DRW + 1;
    localparam int CW  = lpsmd_pkg::CORR_W;
    localparam int TW  = lpsmd_pkg::STEER_W;
    localparam int FW  = lpsmd_pkg::FRAC_W;

    logic [PW-1:0]         pos_c;
    logic signed [EW:0]    err_w;
    logic signed [EW:0]    diff;
    logic signed [PRW-1:0] p_prod;
    logic signed [DRW-1:0] d_prod;
    logic signed [SW-1:0]  sum;
    logic signed [SW-1:0]  biased;
    logic [CW-TW:0]        top_bits;

    always_comb begin
        // positions past the last sensor saturate
        if ({1'b0, i_pos} > (PW+1)'(lpsmd_pkg::POS_MAX)) begin
            pos_c = PW'(lpsmd_pkg::POS_MAX);
        end else begin
            pos_c = i_pos;
        end
        err_w  = $signed({2'b00, pos_c}) - $signed({2'b00, i_cfg.centre});
        o_err  = err_w[EW-1:0];
        diff   = $signed({o_err[EW-1], o_err}) - $signed({i_prev_err[EW-1], i_prev_err});
        p_prod = $signed({1'b0, i_cfg.kp}) * o_err;
        d_prod = $signed({1'b0, i_cfg.kd}) * diff;
        sum    = $signed({{(SW-PRW){p_prod[PRW-1]}}, p_prod})
               + $signed({{(SW-DRW){d_prod[DRW-1]}}, d_prod});
        // round toward zero: bias negatives before the arithmetic shift
        biased = sum + (sum[SW-1] ? SW'((1 << FW) - 1) : SW'(0));
        o_corr = biased[FW+CW-1:FW];
        top_bits = o_corr[CW-1:TW-1];
        if ((&top_bits) || !(|top_bits)) begin
            o_steer = o_corr[TW-1:0];
        end else if (o_corr[CW-1]) begin
            o_steer = {1'b1, {(TW-1){1'b0}}};
        end else begin
            o_steer = {1'b0, {(TW-1){1'b1}}};
        end
    end

endmodule

// ----- hw/rtl/lpsmd_motor_drive.sv -----
// One wheel: base speed plus or minus the correction, clipped, turned into direction and duty.
// Depends on lpsmd_pkg.
module lpsmd_motor_drive (
    input  logic [lpsmd_pkg::SPEED_W-1:0]       i_base,
    input  logic signed [lpsmd_pkg::CORR_W-1:0] i_corr,
    input  logic                                i_sub,
    output lpsmd_pkg::t_wheel                   o_wheel
);
    localparam int CW = lpsmd_pkg::CORR_W;
    localparam int VW = CW + 1;
    localparam int DW = lpsmd_pkg::SPEED_W;

    logic signed [VW-1:0] base_x;
    logic signed [VW-1:0] corr_x;
    logic signed [VW-1:0] speed;
    logic signed [DW:0]   clipped;

    always_comb begin
        base_x = $signed({{(VW-DW){1'b0}}, i_base});
        corr_x = $signed({i_corr[CW-1], i_corr});
        speed  = i_sub ? (base_x - corr_x) : (base_x + corr_x);
        if (speed > VW'(255)) begin
            clipped = (DW+1)'(255);
        end else if (speed < -VW'(255)) begin
            clipped = -(DW+1)'(255);
        end else begin
            clipped = speed[DW:0];
        end
        if (clipped > 0) begin
            o_wheel.forward = 1'b1;
            o_wheel.duty    = 8'd255 - clipped[DW-1:0];
        end else begin
            o_wheel.forward = 1'b0;
            o_wheel.duty    = 8'd0 - clipped[DW-1:0];
        end
    end

endmodule

// ----- hw/rtl/lpsmd_checker.sv -----
// Port-level checks for line_pd_steering_motor_drive, bound to the top level.
// Depends on lpsmd_pkg for widths.
module lpsmd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [lpsmd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    // forward speed is at least 1, so duty never reaches full scale
    a_fwd_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (!m_axis_tdata[0] || m_axis_tdata[8:1] != 8'd255) &&
            (!m_axis_tdata[9] || m_axis_tdata[17:10] != 8'd255))
        else $error("forward wheel with full-scale duty");

    // no steering means both wheels are driven alike
    a_straight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[33:18] == 16'd0) |->
            (m_axis_tdata[8:0] == m_axis_tdata[17:9]))
        else $error("wheels differ with zero steering");

endmodule

bind line_pd_steering_motor_drive lpsmd_checker u_lpsmd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
